### design/smset_pkg.sv
// ----------------------------------------------------------------------------
// smset_pkg - sorted multiset engine package
// Operation and status codes, and the control word sent down the cell row.
// ----------------------------------------------------------------------------
package smset_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_EXISTS = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANK   = 2'd3
    } status_t;

    // broadcast to every cell in the update cycle
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

### design/smset_cell.sv
// ----------------------------------------------------------------------------
// smset_cell - one slot of the sorted register row
// Compares its value with the request and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module smset_cell
(
    input  logic                                      clk,
    input  smset_pkg::cell_ctrl_t                     ctrl,
    input  logic                                      valid,
    input  logic signed [smset_pkg::VALUE_W-1:0]      left_value,
    input  logic                                      left_le,
    input  logic signed [smset_pkg::VALUE_W-1:0]      right_value,
    output logic signed [smset_pkg::VALUE_W-1:0]      stored_value,
    output logic                                      le,
    output logic                                      eq
);

    logic signed [smset_pkg::VALUE_W-1:0] value_reg;
    logic signed [smset_pkg::VALUE_W-1:0] value_next;
    logic                                 lt;

    assign stored_value = value_reg;
    assign lt = valid && (value_reg < ctrl.value);
    assign eq = valid && (value_reg == ctrl.value);
    assign le = lt || eq;

    // insert: slots above the insertion point take the left neighbour,
    // the slot at the point takes the new value.
    // delete: slots at and above the match take the right neighbour.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && !le)
        begin
            value_next = left_le ? ctrl.value : left_value;
        end
        else if (ctrl.del && !lt)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### design/sorted_multiset_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_multiset_engine_top - sorted multiset of signed 32-bit values
// Row of register cells kept in ascending order; insert, delete, test, read.
// ----------------------------------------------------------------------------
// Timing: done is high in the cycle after busy; status, read_value and
// element_count are registered at the end of the busy cycle.
// A start is ignored while busy and is accepted again once busy is low; busy is high for the
// cycle in which the cell row compares and shifts. Results cannot be held off.
// Reset: the count and control clear at once; cell contents stay undefined
// until written and are never read beyond the count.
module sorted_multiset_engine_top
#(
    parameter int CAPACITY = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            operation,
    input  logic signed [smset_pkg::VALUE_W-1:0]  value,
    input  logic [smset_pkg::RANK_W-1:0]          rank_index,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [smset_pkg::VALUE_W-1:0]  read_value,
    output logic [smset_pkg::COUNT_W-1:0]         element_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > smset_pkg::RANK_W) ? CNT_W : smset_pkg::RANK_W;

    logic                                  pending_reg;
    smset_pkg::op_t                        op_reg;
    logic signed [smset_pkg::VALUE_W-1:0]  value_reg;
    logic [smset_pkg::RANK_W-1:0]          rank_reg;
    logic [CNT_W-1:0]                      count_reg;
    logic [CNT_W-1:0]                      count_next;

    logic                                  done_reg;
    smset_pkg::status_t                    status_reg;
    smset_pkg::status_t                    status_next;
    logic signed [smset_pkg::VALUE_W-1:0]  read_value_reg;
    logic signed [smset_pkg::VALUE_W-1:0]  read_value_next;
    logic [smset_pkg::COUNT_W-1:0]         element_count_reg;

    smset_pkg::cell_ctrl_t                 ctrl;
    logic signed [smset_pkg::VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]                   cell_valid;
    logic [CAPACITY-1:0]                   cell_le;
    logic [CAPACITY-1:0]                   cell_eq;

    logic                                  full;
    logic                                  found;
    logic                                  rank_ok;

    assign busy          = pending_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign element_count = element_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= start && !pending_reg;
            done_reg    <= pending_reg;
            if (pending_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !pending_reg)
        begin
            op_reg    <= smset_pkg::op_t'(operation);
            value_reg <= value;
            rank_reg  <= rank_index;
        end
        if (pending_reg)
        begin
            status_reg        <= status_next;
            read_value_reg    <= read_value_next;
            element_count_reg <= smset_pkg::COUNT_W'(count_next);
        end
    end

    // ---- cell row ----
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign found   = |cell_eq;
    assign rank_ok = (CMP_W'(rank_reg) < CMP_W'(count_reg));

    assign ctrl.ins   = pending_reg && (op_reg == smset_pkg::OP_INSERT) && !full;
    assign ctrl.del   = pending_reg && (op_reg == smset_pkg::OP_DELETE) && found;
    assign ctrl.value = value_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [smset_pkg::VALUE_W-1:0] left_value;
            logic                                 left_le;
            logic signed [smset_pkg::VALUE_W-1:0] right_value;

            assign cell_valid[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_value = value_reg;
                assign left_le    = 1'b1;
            end
            else
            begin : g_inner
                assign left_value = cell_value[gi-1];
                assign left_le    = cell_le[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_body
                assign right_value = cell_value[gi+1];
            end

            smset_cell u_cell
            (
                .clk          (clk),
                .ctrl         (ctrl),
                .valid        (cell_valid[gi]),
                .left_value   (left_value),
                .left_le      (left_le),
                .right_value  (right_value),
                .stored_value (cell_value[gi]),
                .le           (cell_le[gi]),
                .eq           (cell_eq[gi])
            );
        end
    endgenerate

    // ---- result ----
    always_comb
    begin
        count_next      = count_reg;
        status_next     = smset_pkg::ST_OK;
        read_value_next = '0;
        case (op_reg)
            smset_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = smset_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            smset_pkg::OP_DELETE:
            begin
                if (!found)
                begin
                    status_next = smset_pkg::ST_ABSENT;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            smset_pkg::OP_EXISTS:
            begin
                if (!found)
                begin
                    status_next = smset_pkg::ST_ABSENT;
                end
            end
            smset_pkg::OP_READ:
            begin
                if (!rank_ok)
                begin
                    status_next = smset_pkg::ST_RANK;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CMP_W'(rank_reg) == CMP_W'(i))
                        begin
                            read_value_next = read_value_next | cell_value[i];
                        end
                    end
                end
            end
            default:
            begin
                status_next = smset_pkg::ST_OK;
            end
        endcase
    end

    // ---- assertions ----
    a_pending_done: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |=> done_reg)
        else $error("request did not complete");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !pending_reg)
        else $error("result while still working");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |=> $stable(count_reg))
        else $error("count moved with no request");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && op_reg == smset_pkg::OP_INSERT && full)
            |=> (status_reg == smset_pkg::ST_FULL) && $stable(count_reg))
        else $error("full insert not refused");

endmodule
